// File: hw/rtl/row_column_key_value_map_defines.svh
// Assertion macros for the row/column map.
// Every check is clocked on clk and held off while rst is high.
`ifndef ROW_COLUMN_KEY_VALUE_MAP_DEFINES_SVH
`define ROW_COLUMN_KEY_VALUE_MAP_DEFINES_SVH

// Same-cycle implication
`define RCKV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("row_column_key_value_map: same-cycle check failed");

// Next-cycle implication
`define RCKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("row_column_key_value_map: next-cycle check failed");

`endif

// File: hw/rtl/rckv_pkg.sv
package rckv_pkg;

  // Operation codes
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Register byte addresses
  localparam logic [1:0] ADDR_SIZE_IN_USE = 2'd0;

  // Value reported when nothing is read back
  localparam logic signed [31:0] VALUE_ABSENT = -32'sd1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One result word
  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    status_t            status;
  } result_t;

endpackage

// File: hw/rtl/rckv_ram.sv
module rckv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rckv_cfg.sv
module rckv_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  size_in_use
);

  import rckv_pkg::*;

  localparam logic [8:0] SIZE_RESET = 9'd256;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_SIZE_IN_USE);

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (wr_en) begin
      size_in_use <= pwdata[8:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SIZE_IN_USE) begin
      prdata = {23'd0, size_in_use};
    end
  end

endmodule

// File: hw/rtl/rckv_seq.sv
module rckv_seq #(
  parameter int MAX_SIZE      = 256,
  parameter int SLOTS_PER_ROW = 8,
  localparam int ROWS  = (MAX_SIZE < 256) ? MAX_SIZE : 256,
  localparam int RW    = $clog2(ROWS),
  localparam int DEPTH = ROWS * SLOTS_PER_ROW,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(SLOTS_PER_ROW + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  operation,
  input  logic [7:0]            row_index,
  input  logic [7:0]            column_index,
  input  logic signed [31:0]    write_value,
  input  logic [8:0]            size_in_use,
  output logic                  busy,
  output logic                  done,
  output rckv_pkg::result_t     result,
  // fill-count memory
  output logic [RW-1:0]         cnt_raddr,
  input  logic [CW-1:0]         cnt_rdata,
  output logic                  cnt_we,
  output logic [RW-1:0]         cnt_waddr,
  output logic [CW-1:0]         cnt_wdata,
  // slot memory: {column, value}
  output logic [AW-1:0]         slot_raddr,
  input  logic [39:0]           slot_rdata,
  output logic                  slot_we,
  output logic [AW-1:0]         slot_waddr,
  output logic [39:0]           slot_wdata
);

  import rckv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_SCAN
  } state_t;

  state_t            state, state_next;
  logic              op_q, op_next;
  logic [RW-1:0]     row_q, row_next;
  logic [7:0]        col_q, col_next;
  logic [31:0]       wval_q, wval_next;
  logic [AW-1:0]     base_q, base_next;
  logic [CW-1:0]     cnt_q, cnt_next;
  logic [CW-1:0]     scan_idx, scan_idx_next;
  logic [ROWS-1:0]   touched, touched_next;
  logic              done_next;
  result_t           result_next;

  logic              in_range;
  logic              hit;
  logic              miss;
  logic [CW-1:0]     miss_cnt;
  logic [CW-1:0]     cnt_eff;

  assign busy = (state != S_IDLE);

  // index check against the configured size and the row count
  assign in_range = ({1'b0, row_index} < size_in_use) &&
                    ({1'b0, column_index} < size_in_use) &&
                    (32'(row_index) < MAX_SIZE) &&
                    (32'(column_index) < MAX_SIZE);

  // the shared column comparator
  assign hit = (slot_rdata[39:32] == col_q);

  // a row never written has no slots in use
  assign cnt_eff = touched[row_q] ? cnt_rdata : '0;

  assign cnt_waddr  = row_q;
  assign slot_wdata = {col_q, wval_q};

  // sequencer
  always_comb begin
    state_next    = state;
    op_next       = op_q;
    row_next      = row_q;
    col_next      = col_q;
    wval_next     = wval_q;
    base_next     = base_q;
    cnt_next      = cnt_q;
    scan_idx_next = scan_idx;
    touched_next  = touched;
    done_next     = 1'b0;
    result_next   = result;
    cnt_raddr     = row_q;
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_q;
    slot_raddr    = base_q;
    slot_we       = 1'b0;
    slot_waddr    = base_q;
    miss          = 1'b0;
    miss_cnt      = cnt_q;

    case (state)
      S_IDLE: begin
        cnt_raddr = row_index[RW-1:0];
        if (start) begin
          op_next   = operation;
          row_next  = row_index[RW-1:0];
          col_next  = column_index;
          wval_next = write_value;
          base_next = AW'(32'(row_index[RW-1:0]) * SLOTS_PER_ROW);
          if (!in_range) begin
            done_next   = 1'b1;
            result_next = '{read_value: VALUE_ABSENT, found: 1'b0, status: STATUS_RANGE};
          end else begin
            state_next = S_COUNT;
          end
        end
      end

      S_COUNT: begin
        // fill count is back; slot 0 is being read
        cnt_next      = cnt_eff;
        scan_idx_next = '0;
        if (cnt_eff == '0) begin
          miss     = 1'b1;
          miss_cnt = cnt_eff;
        end else begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        // compare slot scan_idx, fetch the next one
        slot_raddr = AW'(base_q + AW'(scan_idx) + AW'(1));
        if (hit) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (op_q == OP_GET) begin
            result_next = '{read_value: signed'(slot_rdata[31:0]), found: 1'b1,
                            status: STATUS_OK};
          end else begin
            slot_we     = 1'b1;
            slot_waddr  = AW'(base_q + AW'(scan_idx));
            result_next = '{read_value: VALUE_ABSENT, found: 1'b0, status: STATUS_OK};
          end
        end else if (CW'(scan_idx + CW'(1)) == cnt_q) begin
          miss     = 1'b1;
          miss_cnt = cnt_q;
        end else begin
          scan_idx_next = CW'(scan_idx + CW'(1));
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // column absent from the row: report a miss, append a slot or report a full row
    if (miss) begin
      state_next = S_IDLE;
      done_next  = 1'b1;
      if (op_q == OP_GET) begin
        result_next = '{read_value: VALUE_ABSENT, found: 1'b0, status: STATUS_OK};
      end else if (32'(miss_cnt) < SLOTS_PER_ROW) begin
        slot_we               = 1'b1;
        slot_waddr            = AW'(base_q + AW'(miss_cnt));
        cnt_we                = 1'b1;
        cnt_wdata             = CW'(miss_cnt + CW'(1));
        touched_next[row_q]   = 1'b1;
        result_next = '{read_value: VALUE_ABSENT, found: 1'b0, status: STATUS_OK};
      end else begin
        result_next = '{read_value: VALUE_ABSENT, found: 1'b0, status: STATUS_FULL};
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      touched <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      touched <= touched_next;
      done    <= done_next;
    end
    op_q     <= op_next;
    row_q    <= row_next;
    col_q    <= col_next;
    wval_q   <= wval_next;
    base_q   <= base_next;
    cnt_q    <= cnt_next;
    scan_idx <= scan_idx_next;
    result   <= result_next;
  end

endmodule

// File: hw/rtl/row_column_key_value_map.sv
// Sparse map keyed by a (row, column) pair holding a signed 32-bit value.
// Command channel: an item is taken when start is high and busy is low.
// operation selects a set (store write_value) or a get (return the value).
// Results appear on read_value, found and status, marked by done, which
// is high for a single cycle; the receiver must take them then, as there
// is no back-pressure. An index error returns done in the cycle after
// start. Otherwise the block reads the row's fill count, then compares one
// stored slot per cycle through a single column comparator on the one
// slot-memory read port, until a hit or the end of the row (0 to
// SLOTS_PER_ROW slots compared). busy drops in the cycle done is shown,
// so the next command may be issued in that cycle.
// A set of an absent column appends to the row; a full row reports
// status 2 and stores nothing.
// Reset clears the per-row in-use bits, so every row reads empty at once;
// no clearing pass runs. size_in_use returns to 256 and sits at byte 0 of the
// APB port; the user must write it only while the block is idle, unchecked by the block.
`include "row_column_key_value_map_defines.svh"

module row_column_key_value_map #(
  parameter int MAX_SIZE      = 256,
  parameter int SLOTS_PER_ROW = 8
) (
  input  logic               clk,
  input  logic               rst,
  // command
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [7:0]         row_index,
  input  logic [7:0]         column_index,
  input  logic signed [31:0] write_value,
  // result
  output logic               done,
  output logic signed [31:0] read_value,
  output logic               found,
  output logic [1:0]         status,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import rckv_pkg::*;

  localparam int ROWS  = (MAX_SIZE < 256) ? MAX_SIZE : 256;
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * SLOTS_PER_ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SLOTS_PER_ROW + 1);

  logic [8:0]    size_in_use;
  result_t       result;

  logic [RW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rdata;
  logic          cnt_we;
  logic [RW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  logic [AW-1:0] slot_raddr;
  logic [39:0]   slot_rdata;
  logic          slot_we;
  logic [AW-1:0] slot_waddr;
  logic [39:0]   slot_wdata;

  // configuration registers
  rckv_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .size_in_use (size_in_use)
  );

  // sequencer and comparator
  rckv_seq #(
    .MAX_SIZE      (MAX_SIZE),
    .SLOTS_PER_ROW (SLOTS_PER_ROW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .row_index    (row_index),
    .column_index (column_index),
    .write_value  (write_value),
    .size_in_use  (size_in_use),
    .busy         (busy),
    .done         (done),
    .result       (result),
    .cnt_raddr    (cnt_raddr),
    .cnt_rdata    (cnt_rdata),
    .cnt_we       (cnt_we),
    .cnt_waddr    (cnt_waddr),
    .cnt_wdata    (cnt_wdata),
    .slot_raddr   (slot_raddr),
    .slot_rdata   (slot_rdata),
    .slot_we      (slot_we),
    .slot_waddr   (slot_waddr),
    .slot_wdata   (slot_wdata)
  );

  // per-row fill count
  rckv_ram #(
    .WIDTH (CW),
    .DEPTH (ROWS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // slot store: column and value
  rckv_ram #(
    .WIDTH (40),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign read_value = result.read_value;
  assign found      = result.found;
  assign status     = result.status;

  // checks
  `RCKV_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)
  `RCKV_ASSERT_IMP(a_done_idle, done, !busy)
  `RCKV_ASSERT_IMP(a_found_ok, done && found, status == STATUS_OK)
  `RCKV_ASSERT_IMP(a_absent_value, done && !found, read_value == VALUE_ABSENT)

endmodule
